### rtl/core/lat_pkg.sv
// Shared types and constants for the toroidal Game of Life block.
// Used by life_automaton_torus_top; no dependencies of its own.
package lat_pkg;

	// Fixed field widths of the ports.
	localparam int CFG_WIDTH = 7;
	localparam int IDX_WIDTH = 6;

	// Configuration register indexes.
	localparam logic CFG_COLS = 1'b0;
	localparam logic CFG_ROWS = 1'b1;

	// Dimension limits and reset value.
	localparam int MIN_DIM = 3;
	localparam logic [CFG_WIDTH-1:0] DIM_RESET = 7'd64;

	// B3/S23 neighbor counts.
	localparam logic [3:0] BIRTH_COUNT   = 4'd3;
	localparam logic [3:0] SURVIVE_COUNT = 4'd2;

	typedef enum logic [2:0] {
		MODE_SET   = 3'd0,
		MODE_FLIP  = 3'd1,
		MODE_READ  = 3'd2,
		MODE_STEP  = 3'd3,
		MODE_CLEAR = 3'd4
	} mode_t;

	typedef enum logic [3:0] {
		ST_INIT,
		ST_IDLE,
		ST_MOD,
		ST_LD_UP,
		ST_LD_CUR,
		ST_LD_DN,
		ST_LD_END,
		ST_CELL,
		ST_ROWEND,
		ST_DN_CAP,
		ST_CLR,
		ST_LOOK,
		ST_DONE
	} state_t;

endpackage

### rtl/core/lat_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module lat_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

### rtl/core/life_automaton_torus_top.sv
// Top level of the toroidal Game of Life (B3/S23) block.
// Depends on lat_pkg and lat_ram.
//
// The grid is kept one row per RAM word (MAX_ROWS words of MAX_COLS bits) and
// every request returns the addressed cell after the request is handled. The
// block takes one request at a time. The addresses are first reduced modulo
// the active size by repeated subtraction. Set, flip and read then read the
// addressed row; set and flip write it back patched as the response is issued.
// A generation step walks the active area with one shared neighbor-count unit,
// one cell per cycle within a row, keeping the rows above, at and below in
// registers, and then reads the addressed cell. Clear sweeps every RAM row.
// After reset the same sweep runs once before the first request is taken.
// The user must make configuration writes only while the block is idle; the
// block itself does not enforce this.
module life_automaton_torus_top #(
	parameter int MAX_COLS = 64,
	parameter int MAX_ROWS = 64
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic                           cfg_index,
	input  logic [lat_pkg::CFG_WIDTH-1:0]  cfg_wdata,
	input  logic                           req_valid,
	output logic                           req_ready,
	input  logic [2:0]                     mode,
	input  logic [lat_pkg::IDX_WIDTH-1:0]  col_index,
	input  logic [lat_pkg::IDX_WIDTH-1:0]  row_index,
	input  logic                           cell_value,
	output logic                           rsp_valid,
	input  logic                           rsp_ready,
	output logic                           cell_state
);

	localparam int CW = $clog2(MAX_COLS);
	localparam int RW = $clog2(MAX_ROWS);

	function automatic int clamp_dim(input logic [lat_pkg::CFG_WIDTH-1:0] v, input int maxv);
		int val;
		val = int'(v);
		if (val < lat_pkg::MIN_DIM) begin
			return lat_pkg::MIN_DIM;
		end
		if (val > maxv) begin
			return maxv;
		end
		return val;
	endfunction

	lat_pkg::state_t state_q, state_d;

	logic [CW:0] cols_q;
	logic [RW:0] rows_q;
	logic [RW-1:0] r_q;
	logic [CW-1:0] c_q;
	logic          rsp_valid_q;
	logic          cell_state_q;

	lat_pkg::mode_t              mode_q;
	logic [lat_pkg::IDX_WIDTH-1:0] col_q;
	logic [lat_pkg::IDX_WIDTH-1:0] row_q;
	logic                          val_q;

	logic [MAX_COLS-1:0] up_q, cur_q, dn_q, first_q, new_q;

	logic                ram_we, ram_re;
	logic [RW-1:0]       ram_waddr, ram_raddr;
	logic [MAX_COLS-1:0] ram_wdata, ram_rdata;

	logic [CW-1:0] col_sel, lf, rt;
	logic [RW-1:0] row_sel;
	logic          col_ge, row_ge;
	logic [3:0]    nbr_cnt;
	logic          next_bit;
	logic          c_last, r_last, clr_last;
	logic [RW:0]   r_plus2;
	logic          req_fire, done_fire;
	logic          look_bit, new_cell;
	logic [MAX_COLS-1:0] patched_row;

	lat_ram #(
		.WIDTH(MAX_COLS),
		.DEPTH(MAX_ROWS)
	) u_grid (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign req_ready  = (state_q == lat_pkg::ST_IDLE);
	assign req_fire   = req_valid && req_ready;
	assign rsp_valid  = rsp_valid_q;
	assign cell_state = cell_state_q;

	assign col_sel = CW'(col_q);
	assign row_sel = RW'(row_q);
	assign col_ge  = int'(col_q) >= int'(cols_q);
	assign row_ge  = int'(row_q) >= int'(rows_q);

	// Shared neighbor-count unit: torus wrap on the column, rows come from registers.
	assign lf = (c_q == '0) ? CW'(cols_q - 1'b1) : c_q - 1'b1;
	assign c_last = (({1'b0, c_q} + (CW+1)'(1)) == cols_q);
	assign rt = c_last ? '0 : c_q + 1'b1;
	assign nbr_cnt = 4'(up_q[lf]) + 4'(up_q[c_q]) + 4'(up_q[rt])
	               + 4'(cur_q[lf]) + 4'(cur_q[rt])
	               + 4'(dn_q[lf]) + 4'(dn_q[c_q]) + 4'(dn_q[rt]);
	assign next_bit = cur_q[c_q]
		? (nbr_cnt == lat_pkg::BIRTH_COUNT || nbr_cnt == lat_pkg::SURVIVE_COUNT)
		: (nbr_cnt == lat_pkg::BIRTH_COUNT);

	assign r_last   = (({1'b0, r_q} + (RW+1)'(1)) == rows_q);
	assign r_plus2  = {1'b0, r_q} + (RW+1)'(2);
	assign clr_last = (r_q == RW'(MAX_ROWS - 1));

	always_comb begin
		look_bit = ram_rdata[col_sel];
		case (mode_q)
			lat_pkg::MODE_SET:  new_cell = val_q;
			lat_pkg::MODE_FLIP: new_cell = ~look_bit;
			default:            new_cell = look_bit;
		endcase
		patched_row = ram_rdata;
		patched_row[col_sel] = new_cell;
	end

	always_comb begin
		state_d   = state_q;
		ram_we    = 1'b0;
		ram_waddr = r_q;
		ram_wdata = new_q;
		ram_re    = 1'b0;
		ram_raddr = row_sel;
		done_fire = 1'b0;
		unique case (state_q)
			lat_pkg::ST_INIT: begin
				ram_we    = 1'b1;
				ram_wdata = '0;
				if (clr_last) begin
					state_d = lat_pkg::ST_IDLE;
				end
			end
			lat_pkg::ST_IDLE: begin
				if (req_fire) begin
					state_d = lat_pkg::ST_MOD;
				end
			end
			lat_pkg::ST_MOD: begin
				if (!col_ge && !row_ge) begin
					case (mode_q)
						lat_pkg::MODE_STEP:  state_d = lat_pkg::ST_LD_UP;
						lat_pkg::MODE_CLEAR: state_d = lat_pkg::ST_CLR;
						default:             state_d = lat_pkg::ST_LOOK;
					endcase
				end
			end
			lat_pkg::ST_LD_UP: begin
				ram_re    = 1'b1;
				ram_raddr = RW'(rows_q - 1'b1);
				state_d   = lat_pkg::ST_LD_CUR;
			end
			lat_pkg::ST_LD_CUR: begin
				ram_re    = 1'b1;
				ram_raddr = '0;
				state_d   = lat_pkg::ST_LD_DN;
			end
			lat_pkg::ST_LD_DN: begin
				ram_re    = 1'b1;
				ram_raddr = RW'(1);
				state_d   = lat_pkg::ST_LD_END;
			end
			lat_pkg::ST_LD_END: begin
				state_d = lat_pkg::ST_CELL;
			end
			lat_pkg::ST_CELL: begin
				if (c_last) begin
					state_d = lat_pkg::ST_ROWEND;
				end
			end
			lat_pkg::ST_ROWEND: begin
				ram_we = 1'b1;
				if (r_last) begin
					state_d = lat_pkg::ST_LOOK;
				end else if (r_plus2 == rows_q) begin
					// The row below the last one is the original first row.
					state_d = lat_pkg::ST_CELL;
				end else begin
					ram_re    = 1'b1;
					ram_raddr = RW'(r_plus2);
					state_d   = lat_pkg::ST_DN_CAP;
				end
			end
			lat_pkg::ST_DN_CAP: begin
				state_d = lat_pkg::ST_CELL;
			end
			lat_pkg::ST_CLR: begin
				ram_we    = 1'b1;
				ram_wdata = '0;
				if (clr_last) begin
					state_d = lat_pkg::ST_LOOK;
				end
			end
			lat_pkg::ST_LOOK: begin
				ram_re  = 1'b1;
				state_d = lat_pkg::ST_DONE;
			end
			lat_pkg::ST_DONE: begin
				if (!rsp_valid_q || rsp_ready) begin
					done_fire = 1'b1;
					ram_waddr = row_sel;
					ram_wdata = patched_row;
					ram_we    = (mode_q == lat_pkg::MODE_SET) || (mode_q == lat_pkg::MODE_FLIP);
					state_d   = lat_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = lat_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= lat_pkg::ST_INIT;
			cols_q      <= (CW+1)'(clamp_dim(lat_pkg::DIM_RESET, MAX_COLS));
			rows_q      <= (RW+1)'(clamp_dim(lat_pkg::DIM_RESET, MAX_ROWS));
			r_q         <= '0;
			c_q         <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				unique case (cfg_index)
					lat_pkg::CFG_COLS: cols_q <= (CW+1)'(clamp_dim(cfg_wdata, MAX_COLS));
					lat_pkg::CFG_ROWS: rows_q <= (RW+1)'(clamp_dim(cfg_wdata, MAX_ROWS));
					default: ;
				endcase
			end
			case (state_q) inside
				lat_pkg::ST_INIT, lat_pkg::ST_CLR: begin
					r_q <= clr_last ? '0 : r_q + 1'b1;
				end
				lat_pkg::ST_MOD: begin
					// A step leaves the row counter on its last row, so every sweep starts at row 0.
					r_q <= '0;
				end
				lat_pkg::ST_LD_UP: begin
					r_q <= '0;
				end
				lat_pkg::ST_LD_END: begin
					c_q <= '0;
				end
				lat_pkg::ST_CELL: begin
					c_q <= c_q + 1'b1;
				end
				lat_pkg::ST_ROWEND: begin
					c_q <= '0;
					if (!r_last) begin
						r_q <= r_q + 1'b1;
					end
				end
				default: ;
			endcase
			if (done_fire) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (done_fire) begin
			cell_state_q <= new_cell;
		end
		case (state_q) inside
			lat_pkg::ST_IDLE: begin
				if (req_fire) begin
					mode_q <= lat_pkg::mode_t'(mode);
					col_q  <= col_index;
					row_q  <= row_index;
					val_q  <= cell_value;
				end
			end
			lat_pkg::ST_MOD: begin
				if (col_ge) begin
					col_q <= col_q - lat_pkg::IDX_WIDTH'(cols_q);
				end
				if (row_ge) begin
					row_q <= row_q - lat_pkg::IDX_WIDTH'(rows_q);
				end
			end
			lat_pkg::ST_LD_CUR: begin
				up_q <= ram_rdata;
			end
			lat_pkg::ST_LD_DN: begin
				cur_q   <= ram_rdata;
				first_q <= ram_rdata;
				new_q   <= ram_rdata;
			end
			lat_pkg::ST_LD_END, lat_pkg::ST_DN_CAP: begin
				dn_q <= ram_rdata;
			end
			lat_pkg::ST_CELL: begin
				new_q[c_q] <= next_bit;
			end
			lat_pkg::ST_ROWEND: begin
				// Slide the window down one row; columns beyond the active
				// width keep their old values through new_q.
				if (!r_last) begin
					up_q  <= cur_q;
					cur_q <= dn_q;
					new_q <= dn_q;
					if (r_plus2 == rows_q) begin
						dn_q <= first_q;
					end
				end
			end
			default: ;
		endcase
	end

`ifndef NO_ASSERTIONS
	a_dims_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(int'(cols_q) >= lat_pkg::MIN_DIM && int'(cols_q) <= MAX_COLS
		 && int'(rows_q) >= lat_pkg::MIN_DIM && int'(rows_q) <= MAX_ROWS))
		else $error("active size out of range");

	a_addr_reduced: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == lat_pkg::ST_LOOK) |->
		(int'(col_q) < int'(cols_q) && int'(row_q) < int'(rows_q)))
		else $error("cell address not reduced before lookup");

	a_cell_in_row: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == lat_pkg::ST_CELL) |-> ({1'b0, c_q} < cols_q))
		else $error("step column beyond active width");

	a_step_write_row: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == lat_pkg::ST_ROWEND) |-> ({1'b0, r_q} < rows_q))
		else $error("step writes a row beyond active height");

	a_rsp_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(state_q == lat_pkg::ST_DONE))
		else $error("response raised outside completion");
`endif

endmodule

### bench/tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for life_automaton_torus_top, the toroidal B3/S23 Game of Life block.
// Depends on lat_pkg and the block's RTL; a local copy of the grid predicts every response.
module tb;

	localparam int GRID_COLS_MAX = 64;
	localparam int GRID_ROWS_MAX = 64;
	localparam logic [2:0] MODE_RSVD_FIRST = 3'd5;
	localparam logic [2:0] MODE_RSVD_LAST  = 3'd7;
	localparam int RESET_CYCLES    = 5;
	localparam int WATCHDOG_LIMIT  = 20000;
	localparam int REPORT_LIMIT    = 10;
	localparam int SETTLE_CYCLES   = 50;
	localparam int SIZES_PER_PHASE = 4;
	localparam int ITEMS_PER_SIZE  = 10;

	typedef struct {
		logic [2:0]                    mode;
		logic [lat_pkg::IDX_WIDTH-1:0] col;
		logic [lat_pkg::IDX_WIDTH-1:0] row;
		logic                          cell_state;
	} cell_expect_t;

	logic                          clk        = 1'b0;
	logic                          arst_n     = 1'b0;
	logic                          cfg_we     = 1'b0;
	logic                          cfg_index  = lat_pkg::CFG_COLS;
	logic [lat_pkg::CFG_WIDTH-1:0] cfg_wdata  = '0;
	logic                          req_valid  = 1'b0;
	logic                          req_ready;
	logic [2:0]                    mode       = lat_pkg::MODE_READ;
	logic [lat_pkg::IDX_WIDTH-1:0] col_index  = '0;
	logic [lat_pkg::IDX_WIDTH-1:0] row_index  = '0;
	logic                          cell_value = 1'b0;
	logic                          rsp_valid;
	logic                          rsp_ready  = 1'b0;
	logic                          cell_state;

	// Predicted grid: one word per row, one bit per column.
	logic [GRID_COLS_MAX-1:0] life_grid [GRID_ROWS_MAX] = '{default: '0};
	int unsigned grid_cols = GRID_COLS_MAX;
	int unsigned grid_rows = GRID_ROWS_MAX;

	cell_expect_t expected_cells [$];
	int          mismatch_count = 0;
	int          idle_cycles    = 0;
	int unsigned req_idle_pct   = 0;
	int unsigned rsp_idle_pct   = 0;

	life_automaton_torus_top #(
		.MAX_COLS(GRID_COLS_MAX),
		.MAX_ROWS(GRID_ROWS_MAX)
	) u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.mode      (mode),
		.col_index (col_index),
		.row_index (row_index),
		.cell_value(cell_value),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.cell_state(cell_state)
	);

	always #1 clk = ~clk;

	function automatic int unsigned clamp_dimension(logic [lat_pkg::CFG_WIDTH-1:0] value,
			int unsigned limit);
		if (value < lat_pkg::MIN_DIM) return lat_pkg::MIN_DIM;
		if (value > limit) return limit;
		return 32'(value);
	endfunction

	function automatic void advance_life_grid();
		logic [GRID_COLS_MAX-1:0] next_rows [GRID_ROWS_MAX];
		logic [7:0] window;
		logic [3:0] neighbors;
		int unsigned up, dn, lf, rt;
		// Starting from a copy keeps the cells outside the active area as they are.
		next_rows = life_grid;
		for (int unsigned r = 0; r < grid_rows; r++) begin
			up = (r == 0) ? grid_rows - 1 : r - 1;
			dn = (r + 1 == grid_rows) ? 0 : r + 1;
			for (int unsigned c = 0; c < grid_cols; c++) begin
				lf = (c == 0) ? grid_cols - 1 : c - 1;
				rt = (c + 1 == grid_cols) ? 0 : c + 1;
				window = {life_grid[up][lf], life_grid[up][c], life_grid[up][rt],
					life_grid[r][lf], life_grid[r][rt],
					life_grid[dn][lf], life_grid[dn][c], life_grid[dn][rt]};
				neighbors = 4'($countones(window));
				if (life_grid[r][c])
					next_rows[r][c] = (neighbors == lat_pkg::SURVIVE_COUNT)
						|| (neighbors == lat_pkg::BIRTH_COUNT);
				else
					next_rows[r][c] = (neighbors == lat_pkg::BIRTH_COUNT);
			end
		end
		life_grid = next_rows;
	endfunction

	function automatic logic predict_cell_state(logic [2:0] req_mode,
			logic [lat_pkg::IDX_WIDTH-1:0] col, logic [lat_pkg::IDX_WIDTH-1:0] row,
			logic value);
		int unsigned c, r;
		c = col % grid_cols;
		r = row % grid_rows;
		case (req_mode)
			lat_pkg::MODE_SET:   life_grid[r][c] = value;
			lat_pkg::MODE_FLIP:  life_grid[r][c] = ~life_grid[r][c];
			lat_pkg::MODE_STEP:  advance_life_grid();
			lat_pkg::MODE_CLEAR: life_grid = '{default: '0};
			default: ;
		endcase
		return life_grid[r][c];
	endfunction

	function automatic logic [lat_pkg::CFG_WIDTH-1:0] random_dimension();
		int unsigned pick;
		pick = $urandom_range(9, 0);
		// Mostly small areas keep generation steps short; raw values also hit saturation.
		if (pick < 6) return lat_pkg::CFG_WIDTH'($urandom_range(10, lat_pkg::MIN_DIM));
		if (pick < 9) return lat_pkg::CFG_WIDTH'($urandom_range(2**lat_pkg::CFG_WIDTH - 1, 0));
		return lat_pkg::DIM_RESET;
	endfunction

	function automatic logic [lat_pkg::IDX_WIDTH-1:0] random_index(int unsigned span);
		if ($urandom_range(9, 0) < 8) return lat_pkg::IDX_WIDTH'($urandom_range(span - 1, 0));
		return lat_pkg::IDX_WIDTH'($urandom_range(2**lat_pkg::IDX_WIDTH - 1, 0));
	endfunction

	task automatic issue_request(input logic [2:0] req_mode,
			input logic [lat_pkg::IDX_WIDTH-1:0] col,
			input logic [lat_pkg::IDX_WIDTH-1:0] row, input logic value);
		cell_expect_t item;
		while ($urandom_range(99, 0) < req_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		item.mode = req_mode;
		item.col = col;
		item.row = row;
		item.cell_state = predict_cell_state(req_mode, col, row, value);
		expected_cells.push_back(item);
		req_valid  <= 1'b1;
		mode       <= req_mode;
		col_index  <= col;
		row_index  <= row;
		cell_value <= value;
		@(posedge clk);
		while (!req_ready) @(posedge clk);
	endtask

	task automatic wait_for_responses();
		req_valid <= 1'b0;
		do @(posedge clk); while (expected_cells.size() != 0);
	endtask

	task automatic set_grid_size(input logic [lat_pkg::CFG_WIDTH-1:0] cols_value,
			input logic [lat_pkg::CFG_WIDTH-1:0] rows_value);
		wait_for_responses();
		cfg_we    <= 1'b1;
		cfg_index <= lat_pkg::CFG_COLS;
		cfg_wdata <= cols_value;
		@(posedge clk);
		cfg_index <= lat_pkg::CFG_ROWS;
		cfg_wdata <= rows_value;
		@(posedge clk);
		cfg_we <= 1'b0;
		grid_cols = clamp_dimension(cols_value, GRID_COLS_MAX);
		grid_rows = clamp_dimension(rows_value, GRID_ROWS_MAX);
	endtask

	task automatic test_reset_defaults_and_edges();
		issue_request(lat_pkg::MODE_READ, 6'd0, 6'd0, 1'b1);
		issue_request(lat_pkg::MODE_SET, 6'd63, 6'd63, 1'b1);
		issue_request(lat_pkg::MODE_SET, 6'd0, 6'd63, 1'b1);
		issue_request(lat_pkg::MODE_FLIP, 6'd63, 6'd0, 1'b0);
		issue_request(lat_pkg::MODE_FLIP, 6'd63, 6'd0, 1'b1);
		issue_request(lat_pkg::MODE_SET, 6'd63, 6'd63, 1'b0);
		issue_request(MODE_RSVD_FIRST, 6'd0, 6'd63, 1'b0);
		issue_request(MODE_RSVD_LAST, 6'd63, 6'd63, 1'b1);
		issue_request(lat_pkg::MODE_CLEAR, 6'd0, 6'd63, 1'b1);
		issue_request(lat_pkg::MODE_READ, 6'd0, 6'd63, 1'b0);
	endtask

	task automatic test_size_saturation_and_wrap();
		set_grid_size(7'd0, 7'd127);
		// Column 62 wraps onto column 2 of a three-column torus.
		issue_request(lat_pkg::MODE_SET, 6'd62, 6'd10, 1'b1);
		issue_request(lat_pkg::MODE_READ, 6'd2, 6'd10, 1'b0);
		set_grid_size(7'd127, 7'd1);
		issue_request(lat_pkg::MODE_READ, 6'd62, 6'd10, 1'b0);
	endtask

	task automatic test_generation_step();
		set_grid_size(lat_pkg::DIM_RESET, lat_pkg::DIM_RESET);
		// Vertical blinker straddling the row seam of the full torus.
		issue_request(lat_pkg::MODE_SET, 6'd0, 6'd63, 1'b1);
		issue_request(lat_pkg::MODE_SET, 6'd0, 6'd0, 1'b1);
		issue_request(lat_pkg::MODE_SET, 6'd0, 6'd1, 1'b1);
		issue_request(lat_pkg::MODE_STEP, 6'd63, 6'd0, 1'b0);
		// The live cell in column 63 sits outside the shrunken area and must survive untouched.
		set_grid_size(7'd5, 7'd4);
		issue_request(lat_pkg::MODE_STEP, 6'd0, 6'd0, 1'b0);
		set_grid_size(lat_pkg::DIM_RESET, lat_pkg::DIM_RESET);
		issue_request(lat_pkg::MODE_READ, 6'd63, 6'd0, 1'b0);
		// Clear wipes storage beyond the active area too.
		set_grid_size(7'd3, 7'd3);
		issue_request(lat_pkg::MODE_CLEAR, 6'd2, 6'd2, 1'b1);
		// On the smallest torus every cell touches all others, so three live cells fill it.
		issue_request(lat_pkg::MODE_SET, 6'd0, 6'd0, 1'b1);
		issue_request(lat_pkg::MODE_SET, 6'd1, 6'd1, 1'b1);
		issue_request(lat_pkg::MODE_SET, 6'd2, 6'd1, 1'b1);
		issue_request(lat_pkg::MODE_STEP, 6'd1, 6'd0, 1'b0);
		set_grid_size(lat_pkg::DIM_RESET, lat_pkg::DIM_RESET);
		issue_request(lat_pkg::MODE_READ, 6'd63, 6'd0, 1'b0);
	endtask

	task automatic test_random_traffic(input int unsigned sender_idle,
			input int unsigned receiver_idle);
		logic [2:0] req_mode;
		int unsigned pick;
		req_idle_pct = sender_idle;
		rsp_idle_pct = receiver_idle;
		repeat (SIZES_PER_PHASE) begin
			set_grid_size(random_dimension(), random_dimension());
			repeat (ITEMS_PER_SIZE) begin
				pick = $urandom_range(99, 0);
				if (pick < 35) req_mode = lat_pkg::MODE_SET;
				else if (pick < 55) req_mode = lat_pkg::MODE_FLIP;
				else if (pick < 72) req_mode = lat_pkg::MODE_READ;
				else if (pick < 86) req_mode = lat_pkg::MODE_STEP;
				else if (pick < 89) req_mode = lat_pkg::MODE_CLEAR;
				else req_mode = 3'($urandom_range(MODE_RSVD_LAST, MODE_RSVD_FIRST));
				issue_request(req_mode, random_index(grid_cols), random_index(grid_rows),
					$urandom_range(3, 0) != 0);
			end
		end
	endtask

	always @(posedge clk) begin : check_responses
		cell_expect_t oldest;
		if (arst_n && rsp_valid && rsp_ready) begin
			if (expected_cells.size() == 0) begin
				if (mismatch_count < REPORT_LIMIT)
					$display("response with no request pending: cell_state=%0b", cell_state);
				mismatch_count++;
			end else begin
				oldest = expected_cells.pop_front();
				if (cell_state !== oldest.cell_state) begin
					if (mismatch_count < REPORT_LIMIT)
						$display({"cell_state mismatch: mode %0d col %0d row %0d",
							" expected %0b actual %0b"},
							oldest.mode, oldest.col, oldest.row, oldest.cell_state,
							cell_state);
					mismatch_count++;
				end
			end
		end
		rsp_ready <= ($urandom_range(99, 0) >= rsp_idle_pct);
	end

	always @(posedge clk) begin
		if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("life_automaton_torus_top regression: fail");
			$finish;
		end
	end

	initial begin
		req_idle_pct = 25;
		rsp_idle_pct = 52;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_defaults_and_edges();
		test_size_saturation_and_wrap();
		test_generation_step();
		test_random_traffic(25, 52);
		test_random_traffic(52, 25);
		test_random_traffic(0, 0);
		wait_for_responses();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && expected_cells.size() == 0)
			$display("life_automaton_torus_top regression: pass");
		else
			$display("life_automaton_torus_top regression: fail");
		$finish;
	end

endmodule
